// ----- rtl/xtea_pkg.sv -----
`default_nettype none
package xtea_pkg;

	localparam int unsigned ROUND_CYCLES = 32;
	localparam int unsigned NUM_STAGES   = 2 * ROUND_CYCLES;
	localparam int unsigned NUM_KEYS     = 4;
	localparam int unsigned KEY_IDX_W    = $clog2(NUM_KEYS);
	localparam int unsigned ADDR_W       = KEY_IDX_W + 2;
	localparam logic [31:0] DELTA        = 32'h9E37_79B9;

	localparam logic CMD_ENCIPHER = 1'b0;
	localparam logic CMD_DECIPHER = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] block_word_0;
		logic [31:0] block_word_1;
	} in_t;

	typedef struct packed {
		logic [31:0] out_word_0;
		logic [31:0] out_word_1;
	} out_t;

	function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] sk);
		logic [31:0] t;
		t = (x << 4) ^ (x >> 5);
		return (t + x) ^ sk;
	endfunction

	function automatic logic [31:0] round_sum(input int unsigned n);
		logic [31:0] nw;
		nw = n[31:0];
		return nw * DELTA;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/xtea_block_cipher_core.sv -----
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// block in  | start, busy, data (in_t)                | beat taken on start && !busy
// result    | done, result (out_t)                    | one-cycle strobe, no back-pressure
// config    | psel, penable, pwrite, paddr, pwdata,   | APB, pready always high,
//           | prdata, pready                          | key word i at byte address 4*i
//
// Pipeline of 2*ROUND_CYCLES stages, one half-round (one mix and one add or subtract) per stage.
// A beat is taken every cycle; busy stays low. Each beat passes the stage registers
// in order, and done is the valid bit of the last stage.
// Reset clears the stage valid bits and the key words; nothing stalls inside.
`default_nettype none
module xtea_block_cipher_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  xtea_pkg::in_t              data,
	output logic                             done,
	output xtea_pkg::out_t                   result,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [xtea_pkg::ADDR_W-1:0]      paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int unsigned NS = xtea_pkg::NUM_STAGES;

	logic [31:0] key_q [xtea_pkg::NUM_KEYS];
	logic        cfg_wr;
	logic [xtea_pkg::KEY_IDX_W-1:0] cfg_idx;

	logic        valid_s [NS];
	logic        cmd_s   [NS];
	logic [31:0] y_s     [NS];
	logic [31:0] z_s     [NS];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[xtea_pkg::ADDR_W-1:2];
	assign prdata = key_q[cfg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < xtea_pkg::NUM_KEYS; i++) key_q[i] <= '0;
		end else if (cfg_wr) begin
			key_q[cfg_idx] <= pwdata;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam int unsigned K = i / 2;
		localparam logic [31:0] ESUM = (i % 2 == 0) ? xtea_pkg::round_sum(K)
		                                           : xtea_pkg::round_sum(K + 1);
		localparam logic [31:0] DSUM = (i % 2 == 0)
			? xtea_pkg::round_sum(xtea_pkg::ROUND_CYCLES - K)
			: xtea_pkg::round_sum(xtea_pkg::ROUND_CYCLES - K - 1);
		localparam logic [xtea_pkg::KEY_IDX_W-1:0] EIDX = (i % 2 == 0) ? ESUM[1:0]
		                                                                : ESUM[12:11];
		localparam logic [xtea_pkg::KEY_IDX_W-1:0] DIDX = (i % 2 == 0) ? DSUM[12:11]
		                                                                : DSUM[1:0];

		logic        vin, cin;
		logic [31:0] yin, zin, src, tgt, sk, m, upd;
		logic        tgt_z;

		if (i == 0) begin : g_first
			assign vin = start && !busy;
			assign cin = data.command;
			assign yin = data.block_word_0;
			assign zin = data.block_word_1;
		end else begin : g_next
			assign vin = valid_s[i-1];
			assign cin = cmd_s[i-1];
			assign yin = y_s[i-1];
			assign zin = z_s[i-1];
		end

		// even stages: encipher updates y, decipher updates z; odd stages swap
		assign tgt_z = (i % 2 == 0) ? (cin == xtea_pkg::CMD_DECIPHER)
		                            : (cin == xtea_pkg::CMD_ENCIPHER);
		assign src = tgt_z ? yin : zin;
		assign tgt = tgt_z ? zin : yin;
		assign sk  = (cin == xtea_pkg::CMD_DECIPHER) ? DSUM + key_q[DIDX]
		                                             : ESUM + key_q[EIDX];
		assign m   = xtea_pkg::mix(src, sk);
		assign upd = (cin == xtea_pkg::CMD_DECIPHER) ? tgt - m : tgt + m;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			cmd_s[i] <= cin;
			y_s[i]   <= tgt_z ? yin : upd;
			z_s[i]   <= tgt_z ? upd : zin;
		end
	end

	assign done              = valid_s[NS-1];
	assign result.out_word_0 = y_s[NS-1];
	assign result.out_word_1 = z_s[NS-1];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(xtea_pkg::NUM_STAGES) done)
		else $error("block beat did not finish after the pipeline depth");

	a_cmd_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && data.command == xtea_pkg::CMD_DECIPHER)
		|-> ##(xtea_pkg::NUM_STAGES) (done && cmd_s[NS-1] == xtea_pkg::CMD_DECIPHER))
		else $error("command bit lost in the pipeline");

	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite)
		|=> key_q[$past(paddr[xtea_pkg::ADDR_W-1:2])] == $past(pwdata))
		else $error("key word write not taken");

endmodule
`default_nettype wire
